// ===== hdl/tvft_pkg.sv =====
package tvft_pkg;

    // Component format: signed Q16.16
    localparam int COMP_WIDTH = 32;
    // Reduced vectors carry a 30-bit magnitude; unit vectors are Q2.30
    localparam int MANT_BITS = 30;
    localparam int UNIT_BITS = 30;
    localparam int LEN_W     = 7;
    localparam int WIDE_W    = 64;

    // Unit vector pipeline geometry
    localparam int MAG_W       = MANT_BITS + 1;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int ROOT_W      = 32;
    localparam int QUO_BITS    = UNIT_BITS + 1;
    localparam int NUM_W       = QUO_BITS + MAG_W;
    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 16;
    localparam int UNIT_LAT    = SQRT_STAGES + DIV_STAGES + 4;

    // Opcodes; every other code clears the result
    localparam logic [1:0] OP_FORWARD = 2'd0;
    localparam logic [1:0] OP_INVERSE = 2'd1;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic signed [WIDE_W-1:0]     wide_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec3_t;

    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } wvec3_t;

    function automatic wvec3_t widen(input vec3_t v);
        wvec3_t w;
        w.x = WIDE_W'(v.x);
        w.y = WIDE_W'(v.y);
        w.z = WIDE_W'(v.z);
        return w;
    endfunction

    function automatic logic [WIDE_W-1:0] mag_of(input wide_t v);
        return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    // Bit length of the largest component magnitude (OR of magnitudes)
    function automatic logic [LEN_W-1:0] bit_len(input wvec3_t v);
        logic [WIDE_W-1:0] m;
        logic [LEN_W-1:0]  n;
        m = mag_of(v.x) | mag_of(v.y) | mag_of(v.z);
        n = '0;
        for (int i = 0; i < WIDE_W; i++)
        begin
            if (m[i])
                n = LEN_W'(i + 1);
        end
        return n;
    endfunction

    // Scale so the largest magnitude has MANT_BITS bits; right shift floors
    function automatic vec3_t reduce_shift(input wvec3_t v, input logic [LEN_W-1:0] len);
        vec3_t            o;
        logic [LEN_W-1:0] sh;
        if (len > LEN_W'(MANT_BITS))
        begin
            sh  = len - LEN_W'(MANT_BITS);
            o.x = comp_t'(v.x >>> sh);
            o.y = comp_t'(v.y >>> sh);
            o.z = comp_t'(v.z >>> sh);
        end
        else
        begin
            sh  = LEN_W'(MANT_BITS) - len;
            o.x = comp_t'(v.x <<< sh);
            o.y = comp_t'(v.y <<< sh);
            o.z = comp_t'(v.z <<< sh);
        end
        return o;
    endfunction

endpackage

// ===== hdl/tvft_in_if.sv =====
interface tvft_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    tvft_pkg::comp_t   a_x;
    tvft_pkg::comp_t   a_y;
    tvft_pkg::comp_t   a_z;
    tvft_pkg::comp_t   b_x;
    tvft_pkg::comp_t   b_y;
    tvft_pkg::comp_t   b_z;
    tvft_pkg::comp_t   c_x;
    tvft_pkg::comp_t   c_y;
    tvft_pkg::comp_t   c_z;

    modport source (
        output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        input  ready
    );

    modport sink (
        input  valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
        output ready
    );
endinterface

// ===== hdl/tvft_out_if.sv =====
interface tvft_out_if;
    logic              valid;
    logic              ready;
    tvft_pkg::comp_t   new_a_x;
    tvft_pkg::comp_t   new_a_y;
    tvft_pkg::comp_t   new_a_z;
    tvft_pkg::comp_t   new_b_x;
    tvft_pkg::comp_t   new_b_y;
    tvft_pkg::comp_t   new_b_z;
    tvft_pkg::comp_t   new_c_x;
    tvft_pkg::comp_t   new_c_y;
    tvft_pkg::comp_t   new_c_z;
    logic              degenerate;

    modport source (
        output valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
               new_c_x, new_c_y, new_c_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
               new_c_x, new_c_y, new_c_z, degenerate,
        output ready
    );
endinterface

// ===== hdl/tvft_unit.sv =====
// Pipelined unit vector: square sum, integer square root, rounded division.
// Advances only on cycles with en high.
module tvft_unit (
    input  logic            clk,
    input  logic            en,
    input  tvft_pkg::vec3_t u,
    output tvft_pkg::vec3_t e
);

    localparam int MW = tvft_pkg::MAG_W;
    localparam int WW = tvft_pkg::WIDE_W;
    localparam int RW = tvft_pkg::ROOT_W;
    localparam int NW = tvft_pkg::NUM_W;
    localparam int QB = tvft_pkg::QUO_BITS;
    localparam int SS = tvft_pkg::SQRT_STAGES;
    localparam int DS = tvft_pkg::DIV_STAGES;

    tvft_pkg::comp_t uc [3];
    logic [MW-1:0]   um [3];

    // Stage 1: magnitudes and squares
    logic [MW-1:0]                 mag1_reg [3];
    logic [2:0]                    neg1_reg;
    logic [tvft_pkg::SQ_W-1:0]     sq1_reg  [3];

    // Stage 2: sum of squares
    logic [WW-1:0]                 s2_reg;
    logic [MW-1:0]                 mag2_reg [3];
    logic [2:0]                    neg2_reg;

    // Square root stages
    logic [WW-1:0]                 srem_reg [SS];
    logic [WW-1:0]                 sroot_reg [SS];
    logic [MW-1:0]                 smag_reg [SS][3];
    logic [2:0]                    sneg_reg [SS];

    // Numerator stage
    logic [NW-1:0]                 num_reg [3];
    logic [RW-1:0]                 len_reg;
    logic [2:0]                    nneg_reg;

    // Division stages
    logic [RW-1:0]                 drem_reg [DS][3];
    logic [QB-1:0]                 dquo_reg [DS][3];
    logic [NW-1:0]                 dnum_reg [DS][3];
    logic [RW-1:0]                 dlen_reg [DS];
    logic [2:0]                    dneg_reg [DS];

    tvft_pkg::vec3_t               e_reg;
    tvft_pkg::comp_t               e_next [3];

    assign uc[0] = u.x;
    assign uc[1] = u.y;
    assign uc[2] = u.z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            um[i] = MW'(uc[i][tvft_pkg::COMP_WIDTH-1] ? -uc[i] : uc[i]);
    end

    // Front: squares, then their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= um[i];
                neg1_reg[i] <= uc[i][tvft_pkg::COMP_WIDTH-1];
                sq1_reg[i]  <= tvft_pkg::SQ_W'(um[i]) * tvft_pkg::SQ_W'(um[i]);
            end
            s2_reg   <= WW'(sq1_reg[0]) + WW'(sq1_reg[1]) + WW'(sq1_reg[2]);
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Square root: two digit steps per stage
    for (genvar j = 0; j < SS; j++)
    begin : g_sqrt
        logic [WW-1:0] rem_in;
        logic [WW-1:0] root_in;
        logic [MW-1:0] mag_in [3];
        logic [2:0]    neg_in;
        logic [WW-1:0] rem_next;
        logic [WW-1:0] root_next;
        logic [WW-1:0] bitv;

        if (j == 0)
        begin : g_first
            assign rem_in  = s2_reg;
            assign root_in = '0;
            assign mag_in  = mag2_reg;
            assign neg_in  = neg2_reg;
        end
        else
        begin : g_rest
            assign rem_in  = srem_reg[j-1];
            assign root_in = sroot_reg[j-1];
            assign mag_in  = smag_reg[j-1];
            assign neg_in  = sneg_reg[j-1];
        end

        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            bitv      = '0;
            for (int k = 0; k < 2; k++)
            begin
                bitv = WW'(1) << (62 - 4 * j - 2 * k);
                if (rem_next >= root_next + bitv)
                begin
                    rem_next  = rem_next - (root_next + bitv);
                    root_next = (root_next >> 1) + bitv;
                end
                else
                begin
                    root_next = root_next >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[j]  <= rem_next;
                sroot_reg[j] <= root_next;
                smag_reg[j]  <= mag_in;
                sneg_reg[j]  <= neg_in;
            end
        end
    end

    // Numerator with half-divisor rounding term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                num_reg[i] <= (NW'(smag_reg[SS-1][i]) << tvft_pkg::UNIT_BITS)
                              + NW'(sroot_reg[SS-1][RW-1:1]);
            len_reg  <= sroot_reg[SS-1][RW-1:0];
            nneg_reg <= sneg_reg[SS-1];
        end
    end

    // Restoring division: two quotient bits per stage
    for (genvar j = 0; j < DS; j++)
    begin : g_div
        logic [RW-1:0] rem_in  [3];
        logic [QB-1:0] quo_in  [3];
        logic [NW-1:0] num_in  [3];
        logic [RW-1:0] len_in;
        logic [2:0]    neg_in;
        logic [RW-1:0] rem_next [3];
        logic [QB-1:0] quo_next [3];
        logic [RW:0]   trial;
        // One spare low bit so the last, unused digit position stays in range
        logic [NW:0]   num_pad;
        logic [QB:0]   quo_pad;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_in[i] = num_reg[i];
                    rem_in[i] = RW'(num_reg[i] >> QB);
                    quo_in[i] = '0;
                end
            end
            assign len_in = len_reg;
            assign neg_in = nneg_reg;
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_in[i] = dnum_reg[j-1][i];
                    rem_in[i] = drem_reg[j-1][i];
                    quo_in[i] = dquo_reg[j-1][i];
                end
            end
            assign len_in = dlen_reg[j-1];
            assign neg_in = dneg_reg[j-1];
        end

        always_comb
        begin
            trial   = '0;
            num_pad = '0;
            quo_pad = '0;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = rem_in[i];
                num_pad     = {num_in[i], 1'b0};
                quo_pad     = {quo_in[i], 1'b0};
                for (int k = 0; k < 2; k++)
                begin
                    if (QB - 1 - 2 * j - k >= 0)
                    begin
                        trial = {rem_next[i], num_pad[QB - 2 * j - k]};
                        if (trial >= {1'b0, len_in})
                        begin
                            rem_next[i] = RW'(trial - {1'b0, len_in});
                            quo_pad[QB - 2 * j - k] = 1'b1;
                        end
                        else
                        begin
                            rem_next[i] = trial[RW-1:0];
                        end
                    end
                end
                quo_next[i] = quo_pad[QB:1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[j][i] <= rem_next[i];
                    dquo_reg[j][i] <= quo_next[i];
                    dnum_reg[j][i] <= num_in[i];
                end
                dlen_reg[j] <= len_in;
                dneg_reg[j] <= neg_in;
            end
        end
    end

    // Restore signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dneg_reg[DS-1][i])
                e_next[i] = -tvft_pkg::comp_t'({1'b0, dquo_reg[DS-1][i]});
            else
                e_next[i] = tvft_pkg::comp_t'({1'b0, dquo_reg[DS-1][i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg.x <= e_next[0];
            e_reg.y <= e_next[1];
            e_reg.z <= e_next[2];
        end
    end

    assign e = e_reg;

endmodule

// ===== hdl/three_vector_frame_transform.sv =====
// Three-vector frame transform.
// Channel "operands" carries an opcode and vectors a, b, c (signed Q16.16);
// channel "results" carries the nine transformed components and a
// degenerate flag. A transfer happens when valid and ready are both high.
// The frame is x = unit(a), z = unit(a x b), y = unit(z x a). Forward
// (opcode 0) projects each vector onto the frame rows, inverse (opcode 1)
// uses the transpose, any other opcode yields zeros. With opcode 0 or 1,
// if a is zero or parallel to b the components are zero and degenerate is set.
// The pipeline has 10 stages of vector reduction and cross products,
// 36 in the unit vector pipeline (square root and division, two bits
// per stage) and 3 for the final multiply, sum and rounding. One item
// per cycle is accepted while the pipeline is not frozen.
// Reset clears all valid bits; the pipeline is then empty.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and ready on the input side drops in the same cycle;
// nothing is lost or duplicated.
module three_vector_frame_transform (
    input  logic       clk,
    input  logic       rst_n,
    tvft_in_if.sink    operands,
    tvft_out_if.source results
);

    localparam int UL    = tvft_pkg::UNIT_LAT;
    localparam int TOTAL = UL + 13;
    localparam int LW    = tvft_pkg::LEN_W;

    localparam tvft_pkg::wide_t SAT_MAX =
        (tvft_pkg::wide_t'(1) <<< (tvft_pkg::COMP_WIDTH - 1)) - tvft_pkg::wide_t'(1);
    localparam tvft_pkg::wide_t SAT_MIN = -SAT_MAX - tvft_pkg::wide_t'(1);
    localparam tvft_pkg::wide_t RND_HALF =
        tvft_pkg::wide_t'(1) <<< (tvft_pkg::UNIT_BITS - 1);

    typedef struct packed {
        logic [1:0]      opcode;
        tvft_pkg::vec3_t va;
        tvft_pkg::vec3_t vb;
        tvft_pkg::vec3_t vc;
        logic            ok;
    } carry_t;

    logic                 adv;
    logic                 vld_reg [TOTAL];
    carry_t               c_in;

    carry_t               c_reg [1:10];
    logic [LW-1:0]        la_reg;
    logic [LW-1:0]        lb_reg;
    tvft_pkg::vec3_t      ar_reg [2:10];
    tvft_pkg::vec3_t      br_reg;
    tvft_pkg::wide_t      p_reg [6];
    tvft_pkg::wvec3_t     n_reg;
    tvft_pkg::wvec3_t     n5_reg;
    logic [LW-1:0]        ln_reg;
    tvft_pkg::vec3_t      nr_reg [6:10];
    tvft_pkg::wide_t      q_reg [6];
    tvft_pkg::wvec3_t     y_reg;
    tvft_pkg::wvec3_t     y9_reg;
    logic [LW-1:0]        ly_reg;
    tvft_pkg::vec3_t      yr_reg;

    carry_t               dl_reg [UL];
    tvft_pkg::vec3_t      ex;
    tvft_pkg::vec3_t      ey;
    tvft_pkg::vec3_t      ez;

    tvft_pkg::comp_t      fr  [3][3];
    tvft_pkg::comp_t      cf  [3][3];
    tvft_pkg::comp_t      vin [3][3];
    carry_t               pc_reg;
    tvft_pkg::wide_t      pp_reg [9][3];
    carry_t               sc_reg;
    tvft_pkg::wide_t      sum_reg [9];

    logic                 act;
    tvft_pkg::wide_t      rnd [9];
    tvft_pkg::comp_t      res_next [9];
    logic                 degen_next;
    tvft_pkg::comp_t      res_reg [9];
    logic                 degen_reg;

    // Global advance: the output register is free or being drained
    assign adv             = !vld_reg[TOTAL-1] || results.ready;
    assign operands.ready  = adv;
    assign results.valid   = vld_reg[TOTAL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= operands.valid;
            for (int i = 1; i < TOTAL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Input item
    always_comb
    begin
        c_in.opcode = operands.opcode;
        c_in.va     = '{x: operands.a_x, y: operands.a_y, z: operands.a_z};
        c_in.vb     = '{x: operands.b_x, y: operands.b_y, z: operands.b_z};
        c_in.vc     = '{x: operands.c_x, y: operands.c_y, z: operands.c_z};
        c_in.ok     = 1'b1;
    end

    // Reduction and cross product stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // S1: bit lengths of a and b
            c_reg[1] <= c_in;
            la_reg   <= tvft_pkg::bit_len(tvft_pkg::widen(c_in.va));
            lb_reg   <= tvft_pkg::bit_len(tvft_pkg::widen(c_in.vb));

            // S2: reduced a and b
            c_reg[2]    <= '{opcode: c_reg[1].opcode, va: c_reg[1].va, vb: c_reg[1].vb,
                             vc: c_reg[1].vc, ok: (la_reg != '0)};
            ar_reg[2]   <= tvft_pkg::reduce_shift(tvft_pkg::widen(c_reg[1].va), la_reg);
            br_reg      <= tvft_pkg::reduce_shift(tvft_pkg::widen(c_reg[1].vb), lb_reg);

            // S3: partial products of a x b
            c_reg[3]  <= c_reg[2];
            ar_reg[3] <= ar_reg[2];
            p_reg[0]  <= 64'(ar_reg[2].y) * 64'(br_reg.z);
            p_reg[1]  <= 64'(ar_reg[2].z) * 64'(br_reg.y);
            p_reg[2]  <= 64'(ar_reg[2].z) * 64'(br_reg.x);
            p_reg[3]  <= 64'(ar_reg[2].x) * 64'(br_reg.z);
            p_reg[4]  <= 64'(ar_reg[2].x) * 64'(br_reg.y);
            p_reg[5]  <= 64'(ar_reg[2].y) * 64'(br_reg.x);

            // S4: a x b
            c_reg[4]  <= c_reg[3];
            ar_reg[4] <= ar_reg[3];
            n_reg     <= '{x: p_reg[0] - p_reg[1],
                           y: p_reg[2] - p_reg[3],
                           z: p_reg[4] - p_reg[5]};

            // S5: bit length of normal
            c_reg[5]  <= c_reg[4];
            ar_reg[5] <= ar_reg[4];
            n5_reg    <= n_reg;
            ln_reg    <= tvft_pkg::bit_len(n_reg);

            // S6: reduced normal
            c_reg[6]    <= '{opcode: c_reg[5].opcode, va: c_reg[5].va, vb: c_reg[5].vb,
                             vc: c_reg[5].vc, ok: c_reg[5].ok && (ln_reg != '0)};
            ar_reg[6]   <= ar_reg[5];
            nr_reg[6]   <= tvft_pkg::reduce_shift(n5_reg, ln_reg);

            // S7: partial products of n x a
            c_reg[7]  <= c_reg[6];
            ar_reg[7] <= ar_reg[6];
            nr_reg[7] <= nr_reg[6];
            q_reg[0]  <= 64'(nr_reg[6].y) * 64'(ar_reg[6].z);
            q_reg[1]  <= 64'(nr_reg[6].z) * 64'(ar_reg[6].y);
            q_reg[2]  <= 64'(nr_reg[6].z) * 64'(ar_reg[6].x);
            q_reg[3]  <= 64'(nr_reg[6].x) * 64'(ar_reg[6].z);
            q_reg[4]  <= 64'(nr_reg[6].x) * 64'(ar_reg[6].y);
            q_reg[5]  <= 64'(nr_reg[6].y) * 64'(ar_reg[6].x);

            // S8: n x a
            c_reg[8]  <= c_reg[7];
            ar_reg[8] <= ar_reg[7];
            nr_reg[8] <= nr_reg[7];
            y_reg     <= '{x: q_reg[0] - q_reg[1],
                           y: q_reg[2] - q_reg[3],
                           z: q_reg[4] - q_reg[5]};

            // S9: bit length of y
            c_reg[9]  <= c_reg[8];
            ar_reg[9] <= ar_reg[8];
            nr_reg[9] <= nr_reg[8];
            y9_reg    <= y_reg;
            ly_reg    <= tvft_pkg::bit_len(y_reg);

            // S10: reduced y
            c_reg[10]    <= '{opcode: c_reg[9].opcode, va: c_reg[9].va, vb: c_reg[9].vb,
                              vc: c_reg[9].vc, ok: c_reg[9].ok && (ly_reg != '0)};
            ar_reg[10]   <= ar_reg[9];
            nr_reg[10]   <= nr_reg[9];
            yr_reg       <= tvft_pkg::reduce_shift(y9_reg, ly_reg);

            // Delay line alongside the unit vector pipelines
            dl_reg[0] <= c_reg[10];
            for (int i = 1; i < UL; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    // Frame rows
    tvft_unit u_unit_x (
        .clk (clk),
        .en  (adv),
        .u   (ar_reg[10]),
        .e   (ex)
    );

    tvft_unit u_unit_y (
        .clk (clk),
        .en  (adv),
        .u   (yr_reg),
        .e   (ey)
    );

    tvft_unit u_unit_z (
        .clk (clk),
        .en  (adv),
        .u   (nr_reg[10]),
        .e   (ez)
    );

    // Frame matrix, coefficient select and input vectors
    always_comb
    begin
        fr[0][0] = ex.x;  fr[0][1] = ex.y;  fr[0][2] = ex.z;
        fr[1][0] = ey.x;  fr[1][1] = ey.y;  fr[1][2] = ey.z;
        fr[2][0] = ez.x;  fr[2][1] = ez.y;  fr[2][2] = ez.z;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
                cf[k][j] = (dl_reg[UL-1].opcode == tvft_pkg::OP_FORWARD) ? fr[k][j] : fr[j][k];
        end
        vin[0][0] = dl_reg[UL-1].va.x;  vin[0][1] = dl_reg[UL-1].va.y;
        vin[0][2] = dl_reg[UL-1].va.z;
        vin[1][0] = dl_reg[UL-1].vb.x;  vin[1][1] = dl_reg[UL-1].vb.y;
        vin[1][2] = dl_reg[UL-1].vb.z;
        vin[2][0] = dl_reg[UL-1].vc.x;  vin[2][1] = dl_reg[UL-1].vc.y;
        vin[2][2] = dl_reg[UL-1].vc.z;
    end

    // Rounding, saturation and clearing of the result
    always_comb
    begin
        act = (sc_reg.opcode == tvft_pkg::OP_FORWARD) || (sc_reg.opcode == tvft_pkg::OP_INVERSE);
        for (int m = 0; m < 9; m++)
        begin
            rnd[m] = (sum_reg[m] + RND_HALF) >>> tvft_pkg::UNIT_BITS;
            if (!act || !sc_reg.ok)
                res_next[m] = '0;
            else if (rnd[m] > SAT_MAX)
                res_next[m] = tvft_pkg::comp_t'(SAT_MAX);
            else if (rnd[m] < SAT_MIN)
                res_next[m] = tvft_pkg::comp_t'(SAT_MIN);
            else
                res_next[m] = tvft_pkg::comp_t'(rnd[m]);
        end
        degen_next = act && !sc_reg.ok;
    end

    // Matrix product, row sums and output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pc_reg <= dl_reg[UL-1];
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    for (int j = 0; j < 3; j++)
                        pp_reg[i*3+k][j] <= 64'(cf[k][j]) * 64'(vin[i][j]);
                end
            end

            sc_reg <= pc_reg;
            for (int m = 0; m < 9; m++)
                sum_reg[m] <= pp_reg[m][0] + pp_reg[m][1] + pp_reg[m][2];

            res_reg   <= res_next;
            degen_reg <= degen_next;
        end
    end

    assign results.new_a_x    = res_reg[0];
    assign results.new_a_y    = res_reg[1];
    assign results.new_a_z    = res_reg[2];
    assign results.new_b_x    = res_reg[3];
    assign results.new_b_y    = res_reg[4];
    assign results.new_b_z    = res_reg[5];
    assign results.new_c_x    = res_reg[6];
    assign results.new_c_y    = res_reg[7];
    assign results.new_c_z    = res_reg[8];
    assign results.degenerate = degen_reg;

endmodule
